// ----- src/lazy_range_add_min_tree_core_assert.svh -----
// Assertion macros used by the checker module in lrmt_check.sv.
`ifndef LAZY_RANGE_ADD_MIN_TREE_CORE_ASSERT_SVH
`define LAZY_RANGE_ADD_MIN_TREE_CORE_ASSERT_SVH

// Property that must hold in the same cycle as its trigger.
`define LRMT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its trigger.
`define LRMT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lrmt_pkg.sv -----
package lrmt_pkg;

  localparam int LEAVES = 1024;
  localparam int NODES  = 2 * LEAVES;
  localparam int IDX_W  = $clog2(LEAVES);
  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = IDX_W + 1;
  localparam int DATA_W = 32;
  localparam int LEVELS = IDX_W;
  localparam int DEP_W  = $clog2(LEVELS + 1);
  localparam int STK_W  = $clog2(LEVELS);

  localparam logic [DATA_W-1:0] EMPTY_MIN = 32'd1000000000;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] mn;
    logic [DATA_W-1:0] pend;
  } entry_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [DATA_W-1:0] val;
  } cmd_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    entry_t            wdata;
    logic [NODE_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [DATA_W-1:0] smin(input logic [DATA_W-1:0] a,
                                             input logic [DATA_W-1:0] b);
    return ($signed(b) < $signed(a)) ? b : a;
  endfunction

endpackage

// ----- src/lrmt_ram.sv -----
module lrmt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/lrmt_walk.sv -----
module lrmt_walk import lrmt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              start_i,
  input  cmd_t              cmd_i,
  input  logic [IDX_W-1:0]  last_i,
  input  logic              res_take_i,
  output logic              idle_o,
  output logic              res_valid_o,
  output logic [DATA_W-1:0] res_value_o,
  output mem_req_t          mem_o,
  input  entry_t            rdata_i
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_VISIT = 4'd2;
  localparam logic [3:0] ST_RDU   = 4'd3;
  localparam logic [3:0] ST_PC0   = 4'd4;
  localparam logic [3:0] ST_PC1   = 4'd5;
  localparam logic [3:0] ST_RET   = 4'd6;
  localparam logic [3:0] ST_PL0   = 4'd7;
  localparam logic [3:0] ST_PL1   = 4'd8;
  localparam logic [3:0] ST_PL2   = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [NODE_W-1:0] u_q, u_d, clr_q, clr_d;
  logic [IDX_W-1:0]  l_q, l_d, r_q, r_d;
  logic [DEP_W-1:0]  d_q, d_d, dm1;
  cmd_t              cmd_q, cmd_d;
  logic [DATA_W-1:0] push_q, push_d, tmp_q, tmp_d, best_q, best_d;
  logic              found_q, found_d;
  logic [2*IDX_W-1:0] stk_q [LEVELS];
  logic              stk_we;

  logic [IDX_W:0]    sum;
  logic [IDX_W-1:0]  mid, par_l, par_r;
  logic [NODE_W-1:0] child_l, child_r;
  logic              leaf, covered, disjoint, go_right;

  assign sum      = {1'b0, l_q} + {1'b0, r_q};
  assign mid      = sum[IDX_W:1];
  assign leaf     = (l_q == r_q);
  assign covered  = (cmd_q.lo <= l_q) && (r_q <= cmd_q.hi);
  assign disjoint = (r_q < cmd_q.lo) || (l_q > cmd_q.hi);
  assign go_right = (cmd_q.func == FUNC_WRITE) && (cmd_q.lo > mid);
  assign child_l  = {u_q[NODE_W-2:0], 1'b0};
  assign child_r  = {u_q[NODE_W-2:0], 1'b1};
  assign dm1      = d_q - DEP_W'(1);
  assign {par_l, par_r} = stk_q[dm1[STK_W-1:0]];

  always_comb begin
    state_d = state_q;
    u_d     = u_q;
    l_d     = l_q;
    r_d     = r_q;
    d_d     = d_q;
    cmd_d   = cmd_q;
    push_d  = push_q;
    tmp_d   = tmp_q;
    best_d  = best_q;
    found_d = found_q;
    clr_d   = clr_q;
    stk_we  = 1'b0;
    mem_o   = '0;
    mem_o.raddr = u_q;
    mem_o.waddr = u_q;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = clr_q;
        clr_d       = clr_q + NODE_W'(1);
        if (clr_q == NODE_W'(NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_d   = cmd_i;
          u_d     = NODE_W'(1);
          l_d     = '0;
          r_d     = last_i;
          d_d     = '0;
          found_d = 1'b0;
          best_d  = EMPTY_MIN;
          if ((cmd_i.func == FUNC_WRITE && cmd_i.lo <= last_i) ||
              cmd_i.func == FUNC_ADD || cmd_i.func == FUNC_QUERY) begin
            state_d = ST_VISIT;
          end else begin
            state_d = ST_RET;
          end
        end
      end
      ST_VISIT: begin
        if (cmd_q.func == FUNC_WRITE && leaf) begin
          mem_o.we    = 1'b1;
          mem_o.wdata = '{mn: cmd_q.val, pend: '0};
          state_d     = ST_RET;
        end else if (cmd_q.func != FUNC_WRITE && disjoint) begin
          state_d = ST_RET;
        end else begin
          state_d = ST_RDU;
        end
      end
      ST_RDU: begin
        if (cmd_q.func != FUNC_WRITE && covered) begin
          if (cmd_q.func == FUNC_ADD) begin
            mem_o.we         = 1'b1;
            mem_o.wdata.mn   = rdata_i.mn + cmd_q.val;
            mem_o.wdata.pend = leaf ? rdata_i.pend : rdata_i.pend + cmd_q.val;
          end else begin
            best_d  = found_q ? smin(best_q, rdata_i.mn) : rdata_i.mn;
            found_d = 1'b1;
          end
          state_d = ST_RET;
        end else if (rdata_i.pend != '0) begin
          // owed add goes down to both children before the walk descends
          push_d      = rdata_i.pend;
          mem_o.we    = 1'b1;
          mem_o.wdata = '{mn: rdata_i.mn, pend: '0};
          mem_o.raddr = child_l;
          state_d     = ST_PC0;
        end else begin
          stk_we  = 1'b1;
          d_d     = d_q + DEP_W'(1);
          state_d = ST_VISIT;
          if (go_right) begin
            u_d = child_r;
            l_d = mid + IDX_W'(1);
          end else begin
            u_d = child_l;
            r_d = mid;
          end
        end
      end
      ST_PC0: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = child_l;
        mem_o.wdata = '{mn: rdata_i.mn + push_q, pend: rdata_i.pend + push_q};
        mem_o.raddr = child_r;
        state_d     = ST_PC1;
      end
      ST_PC1: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = child_r;
        mem_o.wdata = '{mn: rdata_i.mn + push_q, pend: rdata_i.pend + push_q};
        stk_we      = 1'b1;
        d_d         = d_q + DEP_W'(1);
        state_d     = ST_VISIT;
        if (go_right) begin
          u_d = child_r;
          l_d = mid + IDX_W'(1);
        end else begin
          u_d = child_l;
          r_d = mid;
        end
      end
      ST_RET: begin
        if (d_q == '0) begin
          state_d = ST_DONE;
        end else if (cmd_q.func != FUNC_WRITE && !u_q[0]) begin
          // left child finished: move over to its sibling
          u_d     = child_r >> 1 | u_q;
          u_d     = {u_q[NODE_W-1:1], 1'b1};
          l_d     = r_q + IDX_W'(1);
          r_d     = par_r;
          state_d = ST_VISIT;
        end else begin
          u_d     = u_q >> 1;
          l_d     = par_l;
          r_d     = par_r;
          d_d     = dm1;
          state_d = (cmd_q.func == FUNC_QUERY) ? ST_RET : ST_PL0;
        end
      end
      ST_PL0: begin
        mem_o.raddr = child_l;
        state_d     = ST_PL1;
      end
      ST_PL1: begin
        tmp_d       = rdata_i.mn;
        mem_o.raddr = child_r;
        state_d     = ST_PL2;
      end
      ST_PL2: begin
        mem_o.we    = 1'b1;
        mem_o.wdata = '{mn: smin(tmp_q, rdata_i.mn), pend: '0};
        state_d     = ST_RET;
      end
      ST_DONE: begin
        if (cmd_q.func != FUNC_QUERY) begin
          state_d = ST_IDLE;
        end else begin
          res_valid_o = 1'b1;
          if (res_take_i) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (clear_i) begin
      state_d = ST_CLEAR;
      clr_d   = '0;
    end
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign res_value_o = found_q ? best_q : EMPTY_MIN;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      d_q     <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      d_q     <= d_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q    <= u_d;
    l_q    <= l_d;
    r_q    <= r_d;
    cmd_q  <= cmd_d;
    push_q <= push_d;
    tmp_q  <= tmp_d;
    best_q <= best_d;
    if (stk_we) begin
      stk_q[d_q[STK_W-1:0]] <= {l_q, r_q};
    end
  end

endmodule

// ----- src/lazy_range_add_min_tree_core.sv -----
// Channel | Direction | Handshake           | Word
// in      | input     | in_valid_i/in_stall_o   | func, range_low, range_high, operand_value
// out     | output    | out_valid_o/out_stall_i | min_value
// cfg     | input     | cfg_valid_i/cfg_ready_o | element_count
//
// One item at a time. Down the tree each node is visited and read, and an owed add is first
// pushed to both children; each node is passed again on return, and an add or write then
// reads both children and writes their minimum back into the node, pulling minima up.
// Reset and every element_count write start a clearing pass over all tree nodes; no word taken.
// A finished query result waits in the output register while the next word is taken;
// a further query stalls the input only at its end.
module lazy_range_add_min_tree_core import lrmt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input words
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               func_i,
  input  logic [IDX_W-1:0]         range_low_i,
  input  logic [IDX_W-1:0]         range_high_i,
  input  logic signed [DATA_W-1:0] operand_value_i,
  // result words
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] min_value_o,
  // element count register
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CNT_W-1:0]         element_count_i
);

  logic              idle, start, cfg_wr, res_valid, res_take;
  logic [DATA_W-1:0] res_value;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  last;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q;
  cmd_t              cmd;
  mem_req_t          mem_req;
  entry_t            mem_rdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // zero reads as one element, anything past the tree size as full size
  always_comb begin
    cnt_d = cnt_q;
    if (cfg_wr) begin
      if (element_count_i == '0) begin
        cnt_d = CNT_W'(1);
      end else if (element_count_i > CNT_W'(LEAVES)) begin
        cnt_d = CNT_W'(LEAVES);
      end else begin
        cnt_d = element_count_i;
      end
    end
  end

  logic [CNT_W-1:0] last_full;
  assign last_full = cnt_q - CNT_W'(1);
  assign last      = last_full[IDX_W-1:0];

  assign in_stall_o = !idle;
  assign start      = in_valid_i && idle;
  assign cmd        = '{func: func_i, lo: range_low_i, hi: range_high_i,
                        val: operand_value_i};

  // output register takes a result whenever it is empty or being drained
  assign res_take    = !out_valid_q || !out_stall_i;
  assign out_valid_d = (res_valid && res_take) ? 1'b1 :
                       (out_stall_i ? out_valid_q : 1'b0);

  lrmt_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_wr),
    .start_i     (start),
    .cmd_i       (cmd),
    .last_i      (last),
    .res_take_i  (res_take),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_value_o (res_value),
    .mem_o       (mem_req),
    .rdata_i     (mem_rdata)
  );

  lrmt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NODES)
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CNT_W'(LEAVES);
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_data_q <= res_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign min_value_o = out_data_q;

endmodule

// ----- src/lrmt_check.sv -----
`include "lazy_range_add_min_tree_core_assert.svh"

module lrmt_check import lrmt_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic [1:0]               func_i,
  input logic [IDX_W-1:0]         range_low_i,
  input logic [IDX_W-1:0]         range_high_i,
  input logic signed [DATA_W-1:0] operand_value_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] min_value_o,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o,
  input logic [CNT_W-1:0]         element_count_i
);

  `LRMT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(min_value_o), "stalled result word changed or dropped")
  `LRMT_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o, "second word taken while a walk should be running")
  `LRMT_ASSERT_NEXT(a_clear_after_cfg, cfg_valid_i && cfg_ready_o, in_stall_o, "word taken during the tree clearing pass")

endmodule

bind lazy_range_add_min_tree_core lrmt_check u_lrmt_check (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import lrmt_pkg::*;

  // func code that the block must drop without a result
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               func_i = FUNC_WRITE;
  logic [IDX_W-1:0]         range_low_i = '0;
  logic [IDX_W-1:0]         range_high_i = '0;
  logic signed [DATA_W-1:0] operand_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b1;
  logic signed [DATA_W-1:0] min_value_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CNT_W-1:0]         element_count_i = '0;

  lazy_range_add_min_tree_core i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .func_i,
    .range_low_i,
    .range_high_i,
    .operand_value_i,
    .out_valid_o,
    .out_stall_i,
    .min_value_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .element_count_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tree predictor: same node layout and lazy adds as the block, so wrapped
  // sums land exactly where the block's would.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] tree_min  [NODES];
  logic [DATA_W-1:0] tree_pend [NODES];
  int                elem_count;

  function automatic logic [DATA_W-1:0] lesser(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    return ($signed(b) < $signed(a)) ? b : a;
  endfunction

  function automatic void tree_clear(int n);
    for (int k = 0; k < NODES; k++) begin
      tree_min[k]  = '0;
      tree_pend[k] = '0;
    end
    elem_count = n;
  endfunction

  // owed add goes down to both children
  function automatic void push_owed(int u);
    logic [DATA_W-1:0] d;
    if (2 * u + 1 >= NODES) return;
    d = tree_pend[u];
    tree_min[2*u]    += d;
    tree_pend[2*u]   += d;
    tree_min[2*u+1]  += d;
    tree_pend[2*u+1] += d;
    tree_pend[u] = '0;
  endfunction

  function automatic void pull_min(int u);
    if (2 * u + 1 >= NODES) return;
    tree_min[u] = lesser(tree_min[2*u], tree_min[2*u+1]);
  endfunction

  function automatic void tree_add(int u, int l, int r, int i, int j, logic [DATA_W-1:0] v);
    int m;
    if (u >= NODES || r < i || l > j) return;
    if (i <= l && r <= j) begin
      tree_min[u] += v;
      if (l != r) tree_pend[u] += v;
      return;
    end
    push_owed(u);
    m = (l + r) / 2;
    tree_add(2 * u, l, m, i, j, v);
    tree_add(2 * u + 1, m + 1, r, i, j, v);
    pull_min(u);
  endfunction

  function automatic void tree_write(int u, int l, int r, int idx, logic [DATA_W-1:0] v);
    int m;
    if (u >= NODES) return;
    if (l == r) begin
      tree_min[u]  = v;
      tree_pend[u] = '0;
      return;
    end
    push_owed(u);
    m = (l + r) / 2;
    if (idx <= m) tree_write(2 * u, l, m, idx, v);
    else tree_write(2 * u + 1, m + 1, r, idx, v);
    pull_min(u);
  endfunction

  function automatic void tree_min_of(int u, int l, int r, int i, int j,
                                      inout bit found, inout logic [DATA_W-1:0] best);
    int m;
    if (u >= NODES || r < i || l > j) return;
    if (i <= l && r <= j) begin
      best  = found ? lesser(best, tree_min[u]) : tree_min[u];
      found = 1'b1;
      return;
    end
    push_owed(u);
    m = (l + r) / 2;
    tree_min_of(2 * u, l, m, i, j, found, best);
    tree_min_of(2 * u + 1, m + 1, r, i, j, found, best);
  endfunction

  // applies one accepted word; returns 1 and the minimum for a query
  function automatic bit apply_word(logic [1:0] f, int lo, int hi, logic [DATA_W-1:0] v,
                                    output logic [DATA_W-1:0] mn);
    bit found;
    logic [DATA_W-1:0] best;
    found = 1'b0;
    best  = EMPTY_MIN;
    mn    = EMPTY_MIN;
    case (f)
      FUNC_WRITE: begin
        if (lo < elem_count) tree_write(1, 0, elem_count - 1, lo, v);
      end
      FUNC_ADD: tree_add(1, 0, elem_count - 1, lo, hi, v);
      FUNC_QUERY: begin
        tree_min_of(1, 0, elem_count - 1, lo, hi, found, best);
        mn = found ? best : EMPTY_MIN;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] min_expected_q[$];
  int errors      = 0;
  int words_sent  = 0;
  int mins_seen   = 0;
  int count_writes = 0;
  bit burst       = 1'b0;   // no idling on either side
  bit hold_req    = 1'b0;   // one long receiver hold-off

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      mins_seen++;
      if (min_expected_q.size() == 0) begin
        $error("min_value: result with none expected, actual %0d", min_value_o);
        errors++;
      end else begin
        if (min_value_o !== min_expected_q[0]) begin
          $error("min_value: expected %0d, actual %0d",
                 $signed(min_expected_q[0]), min_value_o);
          errors++;
        end
        void'(min_expected_q.pop_front());
      end
    end
  end

  // Receiver: draws a stall per result; once holds off long so the block backs up.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) gap = HOLD_CYCLES;
      else if (burst) gap = 0;
      else gap = $urandom_range(0, 9);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Sender: called at a falling edge, returns at a falling edge after acceptance.
  task automatic send_word(logic [1:0] f, int lo, int hi, logic [DATA_W-1:0] v,
                           bit typed, logic [DATA_W-1:0] typed_min);
    int gap;
    logic [DATA_W-1:0] mn;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= f;
    range_low_i     <= lo[IDX_W-1:0];
    range_high_i    <= hi[IDX_W-1:0];
    operand_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    if (apply_word(f, lo, hi, v, mn)) min_expected_q.push_back(typed ? typed_min : mn);
    @(negedge clk_i);
  endtask

  // Let the block go quiet, then write the element count.
  task automatic write_count(int raw);
    int n;
    in_valid_i <= 1'b0;
    wait (min_expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i     <= 1'b1;
    element_count_i <= raw[CNT_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    n = (raw == 0) ? 1 : (raw > LEAVES) ? LEAVES : raw;
    tree_clear(n);
    count_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. cnt >= 0 writes the element count before the row.
  // ---------------------------------------------------------------------------
  typedef struct {
    int                cnt;
    logic [1:0]        f;
    int                lo;
    int                hi;
    logic [DATA_W-1:0] v;
    bit                typed;
    logic [DATA_W-1:0] mn;
  } row_t;

  localparam logic [DATA_W-1:0] S_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] S_MAX = 32'h7FFF_FFFF;

  row_t rows[] = '{
    // fresh tree reads all zero; reversed range is empty
    '{-1, FUNC_QUERY, 0,    1023, 0,             1, 0},
    '{-1, FUNC_QUERY, 5,    3,    0,             1, EMPTY_MIN},
    // signed extremes at both ends
    '{-1, FUNC_WRITE, 0,    0,    S_MIN,         0, 0},
    '{-1, FUNC_WRITE, 1023, 0,    S_MAX,         0, 0},
    '{-1, FUNC_QUERY, 0,    0,    0,             1, S_MIN},
    '{-1, FUNC_QUERY, 1023, 1023, 0,             1, S_MAX},
    '{-1, FUNC_QUERY, 0,    1023, 0,             1, S_MIN},
    // wrapping adds over the whole tree and the interior
    '{-1, FUNC_ADD,   0,    1023, 32'hFFFF_FFFF, 0, 0},
    '{-1, FUNC_QUERY, 0,    1023, 0,             0, 0},
    '{-1, FUNC_ADD,   1,    1022, S_MAX,         0, 0},
    '{-1, FUNC_QUERY, 0,    1023, 0,             0, 0},
    // unknown func and empty add leave the tree alone
    '{-1, FUNC_NONE,  0,    1023, 32'd123,       0, 0},
    '{-1, FUNC_ADD,   10,   5,    32'd5,         0, 0},
    '{-1, FUNC_QUERY, 0,    1023, 0,             0, 0},
    // minimum above the empty marker is still returned
    '{-1, FUNC_WRITE, 512,  0,    32'd2000000000, 0, 0},
    '{-1, FUNC_QUERY, 512,  512,  0,             1, 32'd2000000000},
    '{-1, FUNC_ADD,   300,  700,  32'h5555_5555, 0, 0},
    '{-1, FUNC_QUERY, 300,  700,  0,             0, 0},
    '{-1, FUNC_QUERY, 1023, 0,    0,             1, EMPTY_MIN},
    // small tree: write beyond the count is dropped, ranges clipped
    '{4,  FUNC_WRITE, 10,   0,    32'd77,        0, 0},
    '{-1, FUNC_QUERY, 0,    3,    0,             1, 0},
    '{-1, FUNC_ADD,   2,    1023, 32'd9,         0, 0},
    '{-1, FUNC_QUERY, 2,    1023, 0,             1, 32'd9},
    '{-1, FUNC_QUERY, 4,    1000, 0,             1, EMPTY_MIN}
  };

  function automatic logic [DATA_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0: return S_MIN;
      1: return S_MAX;
      2: return 32'hFFFF_FFFF;
      3, 4, 5: return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return $urandom();
    endcase
  endfunction

  // raw register values, -1 for a random one; 0 and 2047 get clamped by the block
  int counts[] = '{1024, 1, 2, 0, 2047, 7, 1000, 33, -1};

  initial begin
    int n, lo, hi, pick;
    logic [1:0] f;
    tree_clear(LEAVES);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[k]) begin
      if (rows[k].cnt >= 0) write_count(rows[k].cnt);
      send_word(rows[k].f, rows[k].lo, rows[k].hi, rows[k].v, rows[k].typed, rows[k].mn);
    end

    // random phases, one element count each
    foreach (counts[p]) begin
      write_count(counts[p] < 0 ? $urandom_range(3, 1023) : counts[p]);
      n     = elem_count;
      burst = (p == 2 || p == 6);
      // back the pipe up behind a long receiver hold-off
      if (p == 1) hold_req = 1'b1;
      for (int k = 0; k < 125; k++) begin
        pick = $urandom_range(0, 99);
        f = (pick < 30) ? FUNC_WRITE : (pick < 60) ? FUNC_ADD :
            (pick < 95) ? FUNC_QUERY : FUNC_NONE;
        if ($urandom_range(0, 99) < 85) begin
          lo = $urandom_range(0, n - 1);
          hi = $urandom_range(lo, n - 1);
        end else begin
          lo = $urandom_range(0, 1023);
          hi = $urandom_range(0, 1023);
        end
        send_word(f, lo, hi, draw_value(), 0, 0);
      end
      burst = 1'b0;
    end

    in_valid_i <= 1'b0;
    wait (min_expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d words over %0d element count settings; %0d minima checked.",
             words_sent, count_writes, mins_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches.", errors);
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Timeout with %0d minima outstanding.", min_expected_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
